[sv/i2cm_pkg.sv]
// Shared types and constants of the I2C master command and word read core.
package i2cm_pkg;

  // Command codes on the tick channel
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Configuration register indexes
  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic REG_ACK_WAIT_LIMIT = 1'b1;

  // Configuration reset values
  localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd35;
  localparam logic [7:0] ACK_WAIT_LIMIT_RESET = 8'd250;

  // Byte size in bits
  localparam int unsigned BYTE_BITS = 8;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // One result of a tick
  typedef struct packed {
    logic        scl_out;
    logic        sda_out;
    logic        busy_res;
    logic        done_res;
    logic        nack_error;
    logic [15:0] read_word;
  } res_t;

endpackage

[sv/i2cm_tick_if.sv]
// Tick channel: command, command byte and sampled data line.
interface i2cm_tick_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] command_byte;
  logic       sda_in;

  modport source (output valid, output command, output command_byte, output sda_in,
                  input ready);
  modport sink (input valid, input command, input command_byte, input sda_in,
                output ready);
endinterface

[sv/i2cm_result_if.sv]
// Result channel: pin levels, status and last word read.
interface i2cm_result_if;
  logic        valid;
  logic        ready;
  logic        scl_out;
  logic        sda_out;
  logic        busy_res;
  logic        done_res;
  logic        nack_error;
  logic [15:0] read_word;

  modport source (output valid, output scl_out, output sda_out, output busy_res,
                  output done_res, output nack_error, output read_word, input ready);
  modport sink (input valid, input scl_out, input sda_out, input busy_res,
                input done_res, input nack_error, input read_word, output ready);
endinterface

[sv/i2cm_cfg_if.sv]
// Configuration write channel: register index and write data.
interface i2cm_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/i2c_master_command_and_word_read_core.sv]
// I2C master sequencer for one command write and one two-byte word read.
// Results are registered in an output register backed by a one-entry skid stage.
// Throughput: one tick per cycle while the skid stage is empty; the bus sequencer
//   advances one step per tick, and the skid stage absorbs result stalls.
// Reset: synchronous, active high; sequencer idle, word store zero,
//   device address 35, acknowledge wait limit 250, output stages empty.
module i2c_master_command_and_word_read_core (
  input  logic                clk,
  input  logic                rst,
  i2cm_tick_if.sink           tick,
  i2cm_result_if.source       result,
  i2cm_cfg_if.sink            cfg
);
  import i2cm_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST2, PH_ST3, PH_WB1, PH_WB2, PH_WB3, PH_AK1, PH_AK2, PH_AKP,
    PH_RB1, PH_RB2, PH_MA1, PH_MA2, PH_MA3, PH_MA4, PH_MN1, PH_MN2, PH_MN3,
    PH_SP1, PH_SP2, PH_SP3
  } phase_t;

  // Configuration registers
  logic [6:0] device_address;
  logic [7:0] ack_wait_limit;

  // Sequencer state
  phase_t      phase, phase_next;
  logic [1:0]  operation, operation_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] word_store, word_store_next;
  logic [7:0]  ack_wait_count, ack_wait_count_next;
  logic [7:0]  cmd_latch, cmd_latch_next;
  logic [7:0]  high_byte, high_byte_next;
  logic        stage, stage_next;
  logic        err_flag, err_flag_next;

  // Output register and skid stage
  logic res_valid, skid_valid;
  res_t res, skid;
  res_t res_now;

  logic accept;
  logic take;
  logic [3:0] bit_count_inc;
  logic       bit_out;

  assign accept        = tick.valid && tick.ready;
  assign take          = result.valid && result.ready;
  assign tick.ready    = !skid_valid;
  assign cfg.ready     = 1'b1;
  assign bit_count_inc = bit_count + 4'd1;
  assign bit_out       = shift_byte[BYTE_BITS-1];

  // Step the bus sequencer for one tick
  always_comb begin
    phase_next          = phase;
    operation_next      = operation;
    bit_count_next      = bit_count;
    shift_byte_next     = shift_byte;
    word_store_next     = word_store;
    ack_wait_count_next = ack_wait_count;
    cmd_latch_next      = cmd_latch;
    high_byte_next      = high_byte;
    stage_next          = stage;
    err_flag_next       = err_flag;
    res_now.scl_out     = 1'b1;
    res_now.sda_out     = 1'b1;
    res_now.busy_res    = 1'b1;
    res_now.done_res    = 1'b0;
    res_now.nack_error  = 1'b0;
    case (phase)
      PH_ST2: begin
        res_now.sda_out = 1'b0;
        phase_next = PH_ST3;
      end
      PH_ST3: begin
        res_now.scl_out = 1'b0;
        res_now.sda_out = 1'b0;
        bit_count_next = 4'd0;
        phase_next = PH_WB1;
      end
      PH_WB1: begin
        res_now.scl_out = 1'b0;
        res_now.sda_out = bit_out;
        phase_next = PH_WB2;
      end
      PH_WB2: begin
        res_now.sda_out = bit_out;
        phase_next = PH_WB3;
      end
      PH_WB3: begin
        res_now.scl_out = 1'b0;
        res_now.sda_out = bit_out;
        shift_byte_next = {shift_byte[BYTE_BITS-2:0], 1'b0};
        bit_count_next = bit_count_inc;
        if (bit_count_inc >= BITS_PER_BYTE) begin
          ack_wait_count_next = 8'd0;
          phase_next = PH_AK1;
        end else begin
          phase_next = PH_WB1;
        end
      end
      PH_AK1: begin
        res_now.scl_out = 1'b0;
        phase_next = PH_AK2;
      end
      PH_AK2: begin
        phase_next = PH_AKP;
      end
      PH_AKP: begin
        if (!tick.sda_in) begin
          // Acknowledged: release the clock low and move on
          res_now.scl_out = 1'b0;
          bit_count_next = 4'd0;
          if (operation == CMD_READ) begin
            stage_next = 1'b0;
            phase_next = PH_RB1;
          end else if (!stage) begin
            stage_next = 1'b1;
            shift_byte_next = cmd_latch;
            phase_next = PH_WB1;
          end else begin
            phase_next = PH_SP1;
          end
        end else if (ack_wait_count >= ack_wait_limit) begin
          // Timeout: drop into the stop sequence
          res_now.scl_out = 1'b0;
          res_now.sda_out = 1'b0;
          err_flag_next = 1'b1;
          if (operation == CMD_READ) begin
            word_store_next = 16'd0;
          end
          phase_next = PH_SP2;
        end else begin
          ack_wait_count_next = ack_wait_count + 8'd1;
        end
      end
      PH_RB1: begin
        shift_byte_next = {shift_byte[BYTE_BITS-2:0], tick.sda_in};
        phase_next = PH_RB2;
      end
      PH_RB2: begin
        res_now.scl_out = 1'b0;
        bit_count_next = bit_count_inc;
        if (bit_count_inc < BITS_PER_BYTE) begin
          phase_next = PH_RB1;
        end else if (!stage) begin
          high_byte_next = shift_byte;
          phase_next = PH_MA1;
        end else begin
          word_store_next = {high_byte, shift_byte};
          phase_next = PH_MN1;
        end
      end
      PH_MA1: begin
        res_now.scl_out = 1'b0;
        res_now.sda_out = 1'b0;
        phase_next = PH_MA2;
      end
      PH_MA2: begin
        res_now.sda_out = 1'b0;
        phase_next = PH_MA3;
      end
      PH_MA3: begin
        res_now.scl_out = 1'b0;
        res_now.sda_out = 1'b0;
        phase_next = PH_MA4;
      end
      PH_MA4: begin
        res_now.scl_out = 1'b0;
        stage_next = 1'b1;
        bit_count_next = 4'd0;
        shift_byte_next = 8'd0;
        phase_next = PH_RB1;
      end
      PH_MN1: begin
        res_now.scl_out = 1'b0;
        phase_next = PH_MN2;
      end
      PH_MN2: begin
        phase_next = PH_MN3;
      end
      PH_MN3: begin
        res_now.scl_out = 1'b0;
        phase_next = PH_SP1;
      end
      PH_SP1: begin
        res_now.scl_out = 1'b0;
        res_now.sda_out = 1'b0;
        phase_next = PH_SP2;
      end
      PH_SP2: begin
        res_now.sda_out = 1'b0;
        phase_next = PH_SP3;
      end
      PH_SP3: begin
        res_now.done_res = 1'b1;
        res_now.nack_error = err_flag;
        phase_next = PH_IDLE;
      end
      default: begin
        // Idle: start a transaction on a write or read command
        phase_next = PH_IDLE;
        if (tick.command == CMD_WRITE || tick.command == CMD_READ) begin
          operation_next = tick.command;
          cmd_latch_next = tick.command_byte;
          shift_byte_next = {device_address, tick.command == CMD_READ};
          bit_count_next = 4'd0;
          stage_next = 1'b0;
          err_flag_next = 1'b0;
          ack_wait_count_next = 8'd0;
          phase_next = PH_ST2;
        end else begin
          res_now.busy_res = 1'b0;
        end
      end
    endcase
    res_now.read_word = word_store_next;
  end

  // Hold state, configuration and output stages
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEVICE_ADDRESS_RESET;
      ack_wait_limit <= ACK_WAIT_LIMIT_RESET;
      phase          <= PH_IDLE;
      operation      <= CMD_NONE;
      bit_count      <= 4'd0;
      shift_byte     <= 8'd0;
      word_store     <= 16'd0;
      ack_wait_count <= 8'd0;
      cmd_latch      <= 8'd0;
      high_byte      <= 8'd0;
      stage          <= 1'b0;
      err_flag       <= 1'b0;
      res_valid      <= 1'b0;
      skid_valid     <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_DEVICE_ADDRESS: device_address <= cfg.data[6:0];
          REG_ACK_WAIT_LIMIT: ack_wait_limit <= cfg.data;
          default: ;
        endcase
      end
      if (accept) begin
        phase          <= phase_next;
        operation      <= operation_next;
        bit_count      <= bit_count_next;
        shift_byte     <= shift_byte_next;
        word_store     <= word_store_next;
        ack_wait_count <= ack_wait_count_next;
        cmd_latch      <= cmd_latch_next;
        high_byte      <= high_byte_next;
        stage          <= stage_next;
        err_flag       <= err_flag_next;
      end
      // Advance the output register, park in the skid stage on a stall
      if (!res_valid || take) begin
        if (skid_valid) begin
          res        <= skid;
          res_valid  <= 1'b1;
          skid_valid <= accept;
          skid       <= res_now;
        end else begin
          res        <= res_now;
          res_valid  <= accept;
        end
      end else if (accept) begin
        skid       <= res_now;
        skid_valid <= 1'b1;
      end
    end
  end

  assign result.valid      = res_valid;
  assign result.scl_out    = res.scl_out;
  assign result.sda_out    = res.sda_out;
  assign result.busy_res   = res.busy_res;
  assign result.done_res   = res.done_res;
  assign result.nack_error = res.nack_error;
  assign result.read_word  = res.read_word;

  // A finished transaction reports busy on its last tick
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.done_res |-> result.busy_res)
    else $error("done without busy");

  // An error is only reported with done
  a_err_done: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.nack_error |-> result.done_res)
    else $error("nack error without done");

  // The skid stage fills only behind a full output register
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid stage valid with empty output register");

  // The last stop tick returns the sequencer to idle
  a_stop_idle: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_SP3 |=> phase == PH_IDLE && res_valid && result.done_res == 1'b1
      || skid_valid)
    else $error("stop did not return to idle");

endmodule
